### rtl/core/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg: shared types for the shearsort matrix block
// Payload structs, configuration indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package ssm_pkg;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned CFG_W = 4;
	localparam logic CFG_IDX_ROWS = 1'b0;
	localparam logic CFG_IDX_COLS = 1'b1;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic last_in;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic last_out;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_LINE,
		ST_RD_A,
		ST_RD_B,
		ST_CMP,
		ST_WR_A,
		ST_WR_B,
		ST_NEXT,
		ST_OUT_RD,
		ST_OUT_WAIT,
		ST_OUT_SEND
	} state_t;
endpackage
`default_nettype wire

### rtl/core/ssm_ram.sv
// ----------------------------------------------------------------------------
// ssm_ram: generic single-port RAM
// One access per cycle: a read, plus a write when we is set; registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ssm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

### rtl/core/ssm_cmp.sv
// ----------------------------------------------------------------------------
// ssm_cmp: bit-serial signed compare
// Shifts two words MSB first, one bit a cycle, and decides swap order.
// ----------------------------------------------------------------------------
`default_nettype none
module ssm_cmp
	import ssm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              desc,
	input  wire logic [DATA_W-1:0] a,
	input  wire logic [DATA_W-1:0] b,
	output logic                   done,
	output logic                   swap
);
	localparam int unsigned CNT_W = $clog2(DATA_W) + 1;

	logic [DATA_W-1:0] a_q, b_q;
	logic [CNT_W-1:0] cnt_q;
	logic decided_q, lt_q, gt_q, busy_q;

	// first bit is the sign: invert it for signed order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			decided_q <= 1'b0;
			lt_q <= 1'b0;
			gt_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
			decided_q <= 1'b0;
			lt_q <= 1'b0;
			gt_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q == CNT_W'(DATA_W)) begin
				// every bit seen: raise done for one cycle, then go idle
				busy_q <= 1'b0;
			end else begin
				if (!decided_q) begin
					if (((cnt_q == '0) ? ~a_q[DATA_W-1] : a_q[DATA_W-1]) !=
					    ((cnt_q == '0) ? ~b_q[DATA_W-1] : b_q[DATA_W-1])) begin
						decided_q <= 1'b1;
						lt_q <= (cnt_q == '0) ? a_q[DATA_W-1] : b_q[DATA_W-1];
						gt_q <= (cnt_q == '0) ? b_q[DATA_W-1] : a_q[DATA_W-1];
					end
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			a_q <= {a_q[DATA_W-2:0], 1'b0};
			b_q <= {b_q[DATA_W-2:0], 1'b0};
		end
	end

	// a is the earlier element: swap when b should come first
	assign done = busy_q && (cnt_q == CNT_W'(DATA_W));
	assign swap = desc ? lt_q : gt_q;
endmodule
`default_nettype wire

### rtl/core/shearsort_matrix.sv
// ----------------------------------------------------------------------------
// shearsort_matrix: shearsort of a small matrix into snake order
// Loads a matrix row-major, sorts with odd-even transposition per line using
// a bit-serial comparator, then emits it row-major with a last mark.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | word
// in      | input     | in_valid/in_stall  | value, last_in
// out     | output    | out_valid/out_stall| sorted_value, last_out
// cfg     | input     | cfg_we             | rows_used, cols_used by index
//
// Loading accepts one word per cycle. Each line sort runs n passes of odd-even
// transposition; a compare-exchange reads both words over the single RAM port,
// compares them one bit per cycle and writes back a swap. Output registers
// each word read from the RAM before sending. Reset clears control only; the
// store holds what was written. Stalls on the output hold the word in place.
// ----------------------------------------------------------------------------
`default_nettype none
module shearsort_matrix
	import ssm_pkg::*;
#(
	parameter int unsigned MAX_ROWS = 8,
	parameter int unsigned MAX_COLS = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_word_t         in_word,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_word_t             out_word,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);
	localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = 4;

	logic [CFG_W-1:0] rows_q, cols_q;
	logic [CW-1:0] r_eff, c_eff, total;
	state_t state_q, state_d;
	logic [CW-1:0] load_q, line_q, pass_q, pos_q, out_q;
	logic [PW-1:0] phase_q, nphase;
	logic col_mode_q;
	logic [DATA_W-1:0] a_q, b_q;
	logic [AW-1:0] addr_a, addr_b, ram_addr;
	logic ram_we;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;
	logic cmp_done, cmp_swap, swap_q;
	logic line_desc;
	logic [CW-1:0] len, stride, base, lines;
	logic accept;
	logic cmp_start_q;

	always_comb begin
		r_eff = (rows_q == '0) ? CW'(1) :
		        (32'(rows_q) > MAX_ROWS) ? CW'(MAX_ROWS) : CW'(rows_q);
		c_eff = (cols_q == '0) ? CW'(1) :
		        (32'(cols_q) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_q);
		total = CW'(r_eff * c_eff);
		// number of column phases: ceil(log2 rows)
		nphase = '0;
		for (int i = 0; i < 7; i++) begin
			if ((32'd1 << i) < 32'(r_eff)) nphase = PW'(i + 1);
		end
		len = col_mode_q ? r_eff : c_eff;
		lines = col_mode_q ? c_eff : r_eff;
		stride = col_mode_q ? c_eff : CW'(1);
		base = col_mode_q ? line_q : CW'(line_q * c_eff);
		addr_a = AW'(base + pos_q * stride);
		addr_b = AW'(base + (pos_q + CW'(1)) * stride);
	end

	// rows sort ascending on even lines and descending on odd ones
	assign line_desc = !col_mode_q && line_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_W'(8);
			cols_q <= CFG_W'(8);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_ROWS: rows_q <= cfg_data;
				CFG_IDX_COLS: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != ST_LOAD);
	assign accept = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_addr = addr_a;
		ram_wdata = a_q;
		case (state_q)
			ST_LOAD: begin
				ram_addr = AW'(load_q);
				ram_wdata = in_word.value;
				ram_we = accept && (load_q < total);
				if (accept && in_word.last_in) state_d = ST_LINE;
			end
			ST_LINE: state_d = ST_RD_A;
			ST_RD_A: begin
				if (len < CW'(2) || pos_q + CW'(1) >= len) begin
					state_d = ST_NEXT;
				end else begin
					state_d = ST_RD_B;
				end
			end
			ST_RD_B: begin
				ram_addr = addr_b;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				ram_addr = addr_b;
				if (cmp_done) state_d = ST_WR_A;
			end
			ST_WR_A: begin
				ram_we = swap_q;
				ram_wdata = b_q;
				state_d = ST_WR_B;
			end
			ST_WR_B: begin
				ram_addr = addr_b;
				ram_we = swap_q;
				ram_wdata = a_q;
				state_d = ST_RD_A;
			end
			ST_NEXT: begin
				// last pass of the last line of the final row phase: go to output
				if (pass_q + CW'(1) >= len && line_q + CW'(1) >= lines &&
				    !col_mode_q && phase_q == nphase) begin
					state_d = ST_OUT_RD;
				end else begin
					state_d = ST_RD_A;
				end
			end
			ST_OUT_RD: begin
				ram_addr = AW'(out_q);
				state_d = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: state_d = ST_OUT_SEND;
			ST_OUT_SEND: begin
				ram_addr = AW'(out_q);
				if (!out_stall) begin
					state_d = (out_q + CW'(1) == total) ? ST_LOAD : ST_OUT_RD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	ssm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	ssm_cmp u_cmp (
		.clk(clk), .arst_n(arst_n), .start(cmp_start_q), .desc(line_desc),
		.a(a_q), .b(ram_rdata), .done(cmp_done), .swap(cmp_swap)
	);

	// Sequencer: a line is sorted by len passes of odd-even transposition.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			load_q <= '0;
			phase_q <= '0;
			line_q <= '0;
			pass_q <= '0;
			pos_q <= '0;
			out_q <= '0;
			col_mode_q <= 1'b0;
			cmp_start_q <= 1'b0;
			swap_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cmp_start_q <= (state_q == ST_RD_B);
			case (state_q)
				ST_LOAD: begin
					if (accept && in_word.last_in) begin
						load_q <= '0;
						phase_q <= '0;
						line_q <= '0;
						pass_q <= '0;
						pos_q <= '0;
						col_mode_q <= 1'b0;
					end else if (accept && load_q < total) begin
						load_q <= load_q + CW'(1);
					end
				end
				ST_CMP: if (cmp_done) swap_q <= cmp_swap;
				ST_WR_B: pos_q <= pos_q + CW'(2);
				ST_NEXT: begin
					// advance pass, then line, then phase
					if (pass_q + CW'(1) < len) begin
						pass_q <= pass_q + CW'(1);
						pos_q <= CW'(!pass_q[0]);
					end else begin
						pass_q <= '0;
						pos_q <= '0;
						if (line_q + CW'(1) < lines) begin
							line_q <= line_q + CW'(1);
						end else begin
							line_q <= '0;
							if (col_mode_q) begin
								col_mode_q <= 1'b0;
								phase_q <= phase_q + PW'(1);
							end else if (phase_q == nphase) begin
								out_q <= '0;
							end else begin
								col_mode_q <= 1'b1;
							end
						end
					end
				end
				ST_OUT_SEND: if (!out_stall) out_q <= out_q + CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD_B) a_q <= ram_rdata;
		if (state_q == ST_CMP && cmp_done) b_q <= ram_rdata;
		if (state_q == ST_OUT_WAIT) begin
			out_word.sorted_value <= ram_rdata;
			out_word.last_out <= (out_q + CW'(1) == total);
		end
	end

	assign out_valid = (state_q == ST_OUT_SEND);

	// assertions
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open during output");
	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (load_q <= total)) else $error("load count overflow");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("output dropped");
endmodule
`default_nettype wire

### dv/tb_shearsort_matrix.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shearsort_matrix: self-checking bench for the shearsort matrix block
// Loads matrices of several shapes, predicts the snake-ordered result with a
// behavioural shearsort and compares every emitted word field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_shearsort_matrix;
	import ssm_pkg::*;

	localparam int MAX_R = 8;
	localparam int MAX_C = 8;
	localparam int DEPTH = MAX_R * MAX_C;
	localparam longint CYCLE_LIMIT = 2000000;
	// idle gap left between frames
	localparam int SETTLE = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_word;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_IDX_ROWS;
	logic [CFG_W-1:0] cfg_data = '0;

	shearsort_matrix dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state: its own copy of the store and the shape registers
	logic signed [31:0] mesh [DEPTH];
	int unsigned fill_count;
	logic [3:0] rows_reg, cols_reg;
	out_word_t sorted_q[$];
	int errors = 0;
	longint cycles = 0;
	bit calm = 1'b0; // no idling on either side when set

	function automatic int unsigned clamp_dim(logic [3:0] v, int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	// insertion sort of one row or column of the mesh
	function automatic void order_line(int unsigned base, int unsigned stride,
			int unsigned n, bit desc);
		int unsigned j;
		logic signed [31:0] key, prev;
		for (int unsigned i = 1; i < n; i++) begin
			key = mesh[(base + i * stride) % DEPTH];
			j = i;
			while (j > 0) begin
				prev = mesh[(base + (j - 1) * stride) % DEPTH];
				if (desc ? !(prev < key) : !(key < prev))
					break;
				mesh[(base + j * stride) % DEPTH] = prev;
				j--;
			end
			mesh[(base + j * stride) % DEPTH] = key;
		end
	endfunction

	function automatic void sort_rows(int unsigned r, int unsigned c);
		for (int unsigned i = 0; i < r; i++)
			order_line(i * c, 1, c, i[0]);
	endfunction

	// absorb one accepted word; queue the matrix when it closes a frame
	function automatic void absorb_word(in_word_t w);
		int unsigned r, c;
		r = clamp_dim(rows_reg, MAX_R);
		c = clamp_dim(cols_reg, MAX_C);
		if (fill_count < r * c) begin
			mesh[fill_count] = w.value;
			fill_count++;
		end
		if (w.last_in) begin
			for (int unsigned s = 1; s < r; s *= 2) begin
				sort_rows(r, c);
				for (int unsigned k = 0; k < c; k++)
					order_line(k, c, r, 1'b0);
			end
			sort_rows(r, c);
			for (int unsigned k = 0; k < r * c; k++)
				sorted_q.push_back('{sorted_value: mesh[k], last_out: (k + 1 == r * c)});
			fill_count = 0;
		end
	endfunction

	// check each word leaving the block against the oldest expectation
	always @(posedge clk) begin
		out_word_t exp_w;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (sorted_q.size() == 0) begin
				$error("unexpected word %h", out_word);
				errors++;
			end else begin
				exp_w = sorted_q.pop_front();
				if (out_word.sorted_value !== exp_w.sorted_value) begin
					$error("sorted_value expected %0d got %0d",
						exp_w.sorted_value, out_word.sorted_value);
					errors++;
				end
				if (out_word.last_out !== exp_w.last_out) begin
					$error("last_out expected %0b got %0b", exp_w.last_out, out_word.last_out);
					errors++;
				end
			end
		end
		out_stall <= !calm && ($urandom_range(99) < 28);
	end

	always @(posedge clk)
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end

	// write one shape register; only called while the block is idle
	task automatic write_shape(logic idx, logic [3:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IDX_ROWS)
			rows_reg = v;
		else
			cols_reg = v;
	endtask

	// present one word, hold until taken, then maybe drop valid for a gap
	task automatic send_word(logic signed [31:0] v, logic last);
		in_valid <= 1'b1;
		in_word <= '{value: v, last_in: last};
		do @(posedge clk); while (in_stall);
		absorb_word('{value: v, last_in: last});
		while (!calm && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sorted_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// send a full frame of random values; wide or narrow value spread
	task automatic random_frame(int unsigned n);
		logic signed [31:0] v;
		for (int unsigned i = 0; i < n; i++) begin
			v = ($urandom_range(3) == 0) ? $signed($urandom_range(7) - 4) : $urandom;
			send_word(v, i == n - 1);
		end
	endtask

	typedef struct {
		logic signed [31:0] value;
		logic last;
		bit chk;
		logic signed [31:0] exp_first;
		logic signed [31:0] exp_last;
	} stim_row_t;

	// directed table: 2x2 frame of extremes, then a 1x1 frame
	stim_row_t directed[5] = '{
		'{32'sh7FFFFFFF, 1'b0, 1'b0, 32'sd0, 32'sd0},
		'{32'sh80000000, 1'b0, 1'b0, 32'sd0, 32'sd0},
		'{32'sh00000000, 1'b0, 1'b0, 32'sd0, 32'sd0},
		'{-32'sd1, 1'b1, 1'b1, 32'sh80000000, 32'sd0},
		'{32'sh55555555, 1'b1, 1'b1, 32'sh55555555, 32'sh55555555}
	};

	initial begin
		int unsigned r, c, n;
		fill_count = 0;
		rows_reg = 4'd8;
		cols_reg = 4'd8;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// default 8x8 frame first
		random_frame(64);
		drain_results();
		write_shape(CFG_IDX_ROWS, 4'd2);
		write_shape(CFG_IDX_COLS, 4'd2);
		for (int i = 0; i < 5; i++) begin
			if (i == 4) begin
				drain_results();
				write_shape(CFG_IDX_ROWS, 4'd0);
				write_shape(CFG_IDX_COLS, 4'd0);
			end
			send_word(directed[i].value, directed[i].last);
			// frame-closing rows: first and last words of the frame are known
			if (directed[i].chk) begin
				if (sorted_q[0].sorted_value !== directed[i].exp_first) begin
					$error("sorted_value expected %0d got %0d",
						directed[i].exp_first, sorted_q[0].sorted_value);
					errors++;
				end
				if (sorted_q[$].sorted_value !== directed[i].exp_last) begin
					$error("sorted_value expected %0d got %0d",
						directed[i].exp_last, sorted_q[$].sorted_value);
					errors++;
				end
			end
		end
		drain_results();
		// saturating register values, overflow words, then an early last
		write_shape(CFG_IDX_ROWS, 4'd15);
		write_shape(CFG_IDX_COLS, 4'd9);
		for (int i = 0; i < 66; i++)
			send_word($urandom, i == 65);
		drain_results();
		write_shape(CFG_IDX_ROWS, 4'd3);
		write_shape(CFG_IDX_COLS, 4'd3);
		send_word(32'sd5, 1'b0);
		send_word(-32'sd5, 1'b1);
		drain_results();
		// random shapes, mostly small
		calm = 1'b1;
		while (fill_count == 0 && cycles < CYCLE_LIMIT && n < 165) begin
			r = $urandom_range(1, 8);
			c = $urandom_range(1, 8);
			if (r * c > 24)
				c = 24 / r;
			write_shape(CFG_IDX_ROWS, 4'(r));
			write_shape(CFG_IDX_COLS, 4'(c));
			random_frame(r * c);
			n += r * c;
			if (n > 40)
				calm = 1'b0;
			drain_results();
		end
		drain_results();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
